@@ rtl/core/gif_pkg.sv @@
`timescale 1ns / 1ps
package gif_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_RADIUS = 8;

    localparam int PIX_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int PIX_AW    = $clog2(PIX_DEPTH);
    localparam int IDX_W     = $clog2(PIX_DEPTH + 1);
    localparam int DIM_W     = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);
    localparam int RAD_W     = $clog2(MAX_RADIUS + 1);
    localparam int SPAN_W    = $clog2(2 * MAX_RADIUS + 2);
    localparam int CNT_W     = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);

    localparam int FRAC    = 24;
    localparam int Q_W     = 32;
    localparam int Q24P_W  = FRAC + 1;
    localparam int PROD_W  = 2 * Q_W;
    localparam int QM_W    = PROD_W - FRAC;
    localparam int SMP_W   = Q_W + 1;
    localparam int SUM_W   = Q_W + CNT_W + 1;
    localparam int DVD_W   = Q_W + FRAC;
    localparam int DVS_W   = Q_W;
    localparam int QUO_W   = DVD_W + 1;

    localparam int PIX_DW  = 16;
    localparam int COEF_DW = 2 * Q_W;

    localparam int WIDTH_W  = 9;
    localparam int HEIGHT_W = 9;
    localparam int RCFG_W   = 4;
    localparam int EPS_W    = 16;
    localparam int CFG_DW   = 16;
    localparam int CFG_IW   = 2;

    typedef enum logic [CFG_IW-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_RADIUS = 2'd2,
        REG_EPS    = 2'd3
    } t_reg_idx;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    localparam logic signed [QUO_W-1:0] SAT_HI = {{(QUO_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
    localparam logic signed [QUO_W-1:0] SAT_LO = {{(QUO_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};

    // Grey level g mapped to (g << 24) / 255; an 8-bit input makes this a small table.
    function automatic logic [Q24P_W-1:0] to_q24(input logic [7:0] g);
        logic [31:0] t;
        t = {g, 24'd0};
        return Q24P_W'(t / 255);
    endfunction

    function automatic logic signed [Q_W-1:0] sat32(input logic signed [QUO_W-1:0] v);
        logic signed [Q_W-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[Q_W-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[Q_W-1:0];
        end else begin
            res = v[Q_W-1:0];
        end
        return res;
    endfunction

    // Drops the fraction bits of a product, rounding toward zero.
    function automatic logic signed [QM_W-1:0] qtrunc(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] sh;
        logic signed [QM_W-1:0] res;
        mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
        sh  = mag >> FRAC;
        res = p[PROD_W-1] ? -$signed(sh[QM_W-1:0]) : $signed(sh[QM_W-1:0]);
        return res;
    endfunction

endpackage

@@ rtl/core/gif_in_if.sv @@
`timescale 1ns / 1ps
interface gif_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] guide_pixel;
    logic [7:0] source_pixel;

    modport source (output valid, action, guide_pixel, source_pixel, input ready);
    modport sink (input valid, action, guide_pixel, source_pixel, output ready);
endinterface

@@ rtl/core/gif_out_if.sv @@
`timescale 1ns / 1ps
interface gif_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] filtered_pixel;
    logic       last;
    logic       status;

    modport source (output valid, filtered_pixel, last, status, input ready);
    modport sink (input valid, filtered_pixel, last, status, output ready);
endinterface

@@ rtl/core/gif_cfg_if.sv @@
`timescale 1ns / 1ps
interface gif_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [gif_pkg::CFG_IW-1:0]   index;
    logic [gif_pkg::CFG_DW-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/gif_ram.sv @@
`timescale 1ns / 1ps
module gif_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/gif_div.sv @@
`timescale 1ns / 1ps
module gif_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [gif_pkg::DVD_W-1:0]  i_dividend,
    input  logic [gif_pkg::DVS_W-1:0]         i_divisor,
    output logic                              o_busy,
    output logic                              o_done,
    output logic signed [gif_pkg::QUO_W-1:0]  o_quotient
);

    localparam int DCNT_W = $clog2(gif_pkg::DVD_W + 1);

    logic                          r_busy;
    logic                          r_done;
    logic [DCNT_W-1:0]             r_cnt;
    logic [gif_pkg::DVS_W-1:0]     r_rem;
    logic [gif_pkg::DVS_W-1:0]     r_dvs;
    logic [gif_pkg::DVD_W-1:0]     r_q;
    logic                          r_neg;

    logic [gif_pkg::DVS_W:0]       trial;
    logic                          fits;
    logic [gif_pkg::DVS_W:0]       diff;

    // Restoring division on magnitudes, one quotient bit per cycle.
    always_comb begin
        trial = {r_rem, r_q[gif_pkg::DVD_W-1]};
        fits  = trial >= {1'b0, r_dvs};
        diff  = trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(gif_pkg::DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_neg <= i_dividend[gif_pkg::DVD_W-1];
            r_q   <= i_dividend[gif_pkg::DVD_W-1] ? gif_pkg::DVD_W'(-i_dividend)
                                                  : gif_pkg::DVD_W'(i_dividend);
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[gif_pkg::DVD_W-2:0], fits};
            r_rem <= fits ? diff[gif_pkg::DVS_W-1:0] : trial[gif_pkg::DVS_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});

endmodule

@@ rtl/core/guided_image_filter_unit.sv @@
`timescale 1ns / 1ps
// A load item is accepted only in the idle state; the load that completes the frame starts the
// coefficient pass, whose pace per pixel is set by the
// single pixel-store read port and the shared one-bit-per-cycle divider.
// A request item gives its result after a window pass over the coefficient store and two divisions.
// One item is worked on at a time. Reset clears the control state and restores the
// register defaults; the pixel and coefficient stores keep whatever they hold.
module guided_image_filter_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    gif_in_if.sink           i_in,
    gif_out_if.source        o_out,
    gif_cfg_if.sink          i_cfg
);

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_BASE, S_SCAN, S_DRAIN, S_DIV,
        S_C_M1, S_C_VAR, S_C_M2, S_C_COV, S_C_DIVA, S_C_M3, S_C_B,
        S_R_M, S_R_Q, S_OUT
    } t_state;

    t_state r_state;

    logic [gif_pkg::WIDTH_W-1:0]  r_cfg_w;
    logic [gif_pkg::HEIGHT_W-1:0] r_cfg_h;
    logic [gif_pkg::RCFG_W-1:0]   r_cfg_r;
    logic [gif_pkg::EPS_W-1:0]    r_cfg_eps;

    logic [gif_pkg::IDX_W-1:0] r_load_idx;
    logic [gif_pkg::IDX_W-1:0] r_emit;
    logic [gif_pkg::DIM_W-1:0] r_ey, r_ex;
    logic                      r_frame_ready;
    logic                      r_coef_mode;

    logic [gif_pkg::DIM_W-1:0] r_py, r_px;
    logic [gif_pkg::IDX_W-1:0] r_pidx;
    logic [gif_pkg::DIM_W-1:0] r_y0, r_y1, r_x0, r_x1;
    logic [gif_pkg::DIM_W-1:0] r_sy, r_sx;
    logic [gif_pkg::IDX_W-1:0] r_row_base;
    logic [gif_pkg::CNT_W-1:0] r_count;
    logic [7:0]                r_gi;

    logic r_v1, r_v2, r_v3;
    logic signed [gif_pkg::SMP_W-1:0] r_t0, r_t1;
    logic signed [gif_pkg::SMP_W-1:0] r_u0, r_u1, r_u2, r_u3;
    logic signed [gif_pkg::SUM_W-1:0] r_sum [4];

    logic [1:0]                     r_k;
    logic                           r_div_start;
    logic                           r_div_go;
    logic signed [gif_pkg::Q_W-1:0] r_mean [4];
    logic signed [gif_pkg::QM_W-1:0] r_prod;
    logic signed [gif_pkg::Q_W-1:0] r_var, r_cov, r_a;
    logic [gif_pkg::DVS_W-1:0]      r_den;

    logic       r_res_ok;
    logic [7:0] r_res_fp;
    logic       r_res_last;
    logic       r_res_status;

    logic       r_out_valid;
    logic [7:0] r_out_fp;
    logic       r_out_last;
    logic       r_out_status;

    logic in_acc, cfg_acc, out_free;
    logic [gif_pkg::DIM_W-1:0] w_eff, h_eff;
    logic [gif_pkg::RAD_W-1:0] r_eff;
    logic [gif_pkg::IDX_W-1:0] n_pix;
    logic [gif_pkg::IDX_W-1:0] ld_base, ld_next;
    logic                      ld_wr;
    logic [gif_pkg::IDX_W-1:0] scan_addr;
    logic [gif_pkg::DIM_W-1:0] r_ext;
    logic [gif_pkg::DIM_W:0]   y_hi_t, x_hi_t;
    logic [gif_pkg::DIM_W-1:0] y_lo, y_hi, x_lo, x_hi;
    logic [gif_pkg::SPAN_W-1:0] span_y, span_x;

    logic [gif_pkg::PIX_AW-1:0] pix_raddr;
    logic [gif_pkg::PIX_DW-1:0] pix_rd;
    logic [gif_pkg::COEF_DW-1:0] coef_rd;
    logic                        coef_we;
    logic [gif_pkg::COEF_DW-1:0] coef_wd;

    logic [gif_pkg::Q24P_W-1:0] iv_st, pv_st;
    logic [2*gif_pkg::Q24P_W-1:0] ii_full, ip_full;

    logic signed [gif_pkg::DVD_W-1:0] div_dvd;
    logic [gif_pkg::DVS_W-1:0]        div_dvs;
    logic                             div_busy, div_done;
    logic signed [gif_pkg::QUO_W-1:0] div_quo;
    logic [1:0]                       k_last;

    logic signed [gif_pkg::Q_W-1:0]    mul_a, mul_b;
    logic signed [gif_pkg::PROD_W-1:0] mul_p;
    logic signed [gif_pkg::Q_W-1:0]    eps_q;
    logic signed [gif_pkg::QUO_W-1:0]  var_full, cov_full, den_full, b_full, q_full;
    logic signed [gif_pkg::Q_W-1:0]    cov_v, b_v, q_v;
    logic signed [gif_pkg::Q_W+8:0]    s_full;
    logic [7:0]                        fp_v;

    assign in_acc   = i_in.valid && i_in.ready;
    assign cfg_acc  = i_cfg.valid && i_cfg.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready  = (r_state == S_IDLE) && !i_cfg.valid;
    assign i_cfg.ready = (r_state == S_IDLE);

    assign o_out.valid          = r_out_valid;
    assign o_out.filtered_pixel = r_out_fp;
    assign o_out.last           = r_out_last;
    assign o_out.status         = r_out_status;

    // Effective frame geometry.
    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = gif_pkg::DIM_W'(1);
        end else if (gif_pkg::DIM_W'(r_cfg_w) > gif_pkg::DIM_W'(gif_pkg::MAX_WIDTH)) begin
            w_eff = gif_pkg::DIM_W'(gif_pkg::MAX_WIDTH);
        end else begin
            w_eff = gif_pkg::DIM_W'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h_eff = gif_pkg::DIM_W'(1);
        end else if (gif_pkg::DIM_W'(r_cfg_h) > gif_pkg::DIM_W'(gif_pkg::MAX_HEIGHT)) begin
            h_eff = gif_pkg::DIM_W'(gif_pkg::MAX_HEIGHT);
        end else begin
            h_eff = gif_pkg::DIM_W'(r_cfg_h);
        end
        if (gif_pkg::RAD_W'(r_cfg_r) > gif_pkg::RAD_W'(gif_pkg::MAX_RADIUS)
                || (r_cfg_r >> gif_pkg::RAD_W) != '0) begin
            r_eff = gif_pkg::RAD_W'(gif_pkg::MAX_RADIUS);
        end else begin
            r_eff = gif_pkg::RAD_W'(r_cfg_r);
        end
        n_pix = gif_pkg::IDX_W'(w_eff * h_eff);
    end

    always_comb begin
        ld_base = r_frame_ready ? '0 : r_load_idx;
        ld_wr   = in_acc && (i_in.action == gif_pkg::ACT_LOAD) && (ld_base < n_pix);
        ld_next = ld_wr ? ld_base + 1'b1 : ld_base;
    end

    // Clipped window around the current pixel.
    always_comb begin
        r_ext  = gif_pkg::DIM_W'(r_eff);
        y_lo   = (r_py >= r_ext) ? r_py - r_ext : '0;
        x_lo   = (r_px >= r_ext) ? r_px - r_ext : '0;
        y_hi_t = {1'b0, r_py} + {1'b0, r_ext};
        x_hi_t = {1'b0, r_px} + {1'b0, r_ext};
        y_hi   = (y_hi_t < {1'b0, h_eff}) ? y_hi_t[gif_pkg::DIM_W-1:0] : h_eff - 1'b1;
        x_hi   = (x_hi_t < {1'b0, w_eff}) ? x_hi_t[gif_pkg::DIM_W-1:0] : w_eff - 1'b1;
        span_y = gif_pkg::SPAN_W'(r_y1 - r_y0 + 1'b1);
        span_x = gif_pkg::SPAN_W'(r_x1 - r_x0 + 1'b1);
    end

    assign scan_addr = r_row_base + gif_pkg::IDX_W'(r_sx);
    assign pix_raddr = (r_state == S_SCAN) ? scan_addr[gif_pkg::PIX_AW-1:0]
                                           : r_emit[gif_pkg::PIX_AW-1:0];

    gif_ram #(
        .DATA_W (gif_pkg::PIX_DW),
        .DEPTH  (gif_pkg::PIX_DEPTH)
    ) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (ld_wr),
        .i_waddr (ld_base[gif_pkg::PIX_AW-1:0]),
        .i_wdata ({i_in.guide_pixel, i_in.source_pixel}),
        .i_raddr (pix_raddr),
        .o_rdata (pix_rd)
    );

    gif_ram #(
        .DATA_W (gif_pkg::COEF_DW),
        .DEPTH  (gif_pkg::PIX_DEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (r_pidx[gif_pkg::PIX_AW-1:0]),
        .i_wdata (coef_wd),
        .i_raddr (scan_addr[gif_pkg::PIX_AW-1:0]),
        .o_rdata (coef_rd)
    );

    always_comb begin
        iv_st   = gif_pkg::to_q24(pix_rd[15:8]);
        pv_st   = gif_pkg::to_q24(pix_rd[7:0]);
        ii_full = r_t0[gif_pkg::Q24P_W-1:0] * r_t0[gif_pkg::Q24P_W-1:0];
        ip_full = r_t0[gif_pkg::Q24P_W-1:0] * r_t1[gif_pkg::Q24P_W-1:0];
    end

    // Divider operands: a window mean, or the coefficient a.
    always_comb begin
        if (r_state == S_C_DIVA) begin
            div_dvd = {r_cov, {gif_pkg::FRAC{1'b0}}};
            div_dvs = r_den;
        end else begin
            div_dvd = gif_pkg::DVD_W'(r_sum[r_k]);
            div_dvs = gif_pkg::DVS_W'(r_count);
        end
        k_last = r_coef_mode ? 2'd1 : 2'd3;
    end

    gif_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Shared multiplier for the scalar steps.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_C_M1: begin
                mul_a = r_mean[0];
                mul_b = r_mean[0];
            end
            S_C_M2: begin
                mul_a = r_mean[0];
                mul_b = r_mean[1];
            end
            S_C_M3: begin
                mul_a = r_a;
                mul_b = r_mean[0];
            end
            S_R_M: begin
                mul_a = r_mean[0];
                mul_b = $signed(gif_pkg::Q_W'(gif_pkg::to_q24(r_gi)));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        eps_q    = $signed({{(gif_pkg::Q_W-gif_pkg::EPS_W-8){1'b0}}, r_cfg_eps, 8'd0});
        var_full = gif_pkg::QUO_W'(r_mean[2]) - gif_pkg::QUO_W'(r_prod);
        cov_full = gif_pkg::QUO_W'(r_mean[3]) - gif_pkg::QUO_W'(r_prod);
        cov_v    = gif_pkg::sat32(cov_full);
        den_full = gif_pkg::QUO_W'(r_var) + gif_pkg::QUO_W'(eps_q);
        b_full   = gif_pkg::QUO_W'(r_mean[1]) - gif_pkg::QUO_W'(r_prod);
        b_v      = gif_pkg::sat32(b_full);
        q_full   = gif_pkg::QUO_W'(r_prod) + gif_pkg::QUO_W'(r_mean[1]);
        q_v      = gif_pkg::sat32(q_full);
        s_full   = ((gif_pkg::Q_W+9)'(q_v) <<< 8) - (gif_pkg::Q_W+9)'(q_v);
        if (q_v < 0) begin
            fp_v = 8'd0;
        end else if (s_full[gif_pkg::Q_W+8:gif_pkg::FRAC+8] != '0) begin
            fp_v = 8'd255;
        end else begin
            fp_v = s_full[gif_pkg::FRAC+7:gif_pkg::FRAC];
        end
        coef_we = (r_state == S_C_B);
        coef_wd = {r_a, b_v};
    end

    // Window read pipeline: store read, sample conversion, products, accumulate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= (r_state == S_SCAN);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_coef_mode) begin
            r_t0 <= gif_pkg::SMP_W'($signed(coef_rd[gif_pkg::COEF_DW-1:gif_pkg::Q_W]));
            r_t1 <= gif_pkg::SMP_W'($signed(coef_rd[gif_pkg::Q_W-1:0]));
        end else begin
            r_t0 <= $signed(gif_pkg::SMP_W'(iv_st));
            r_t1 <= $signed(gif_pkg::SMP_W'(pv_st));
        end
        r_u0 <= r_t0;
        r_u1 <= r_t1;
        r_u2 <= $signed(gif_pkg::SMP_W'(ii_full[gif_pkg::FRAC+gif_pkg::Q24P_W-1:gif_pkg::FRAC]));
        r_u3 <= $signed(gif_pkg::SMP_W'(ip_full[gif_pkg::FRAC+gif_pkg::Q24P_W-1:gif_pkg::FRAC]));
        if (r_state == S_BASE) begin
            r_sum[0] <= '0;
            r_sum[1] <= '0;
            r_sum[2] <= '0;
            r_sum[3] <= '0;
        end else if (r_v3) begin
            r_sum[0] <= r_sum[0] + gif_pkg::SUM_W'(r_u0);
            r_sum[1] <= r_sum[1] + gif_pkg::SUM_W'(r_u1);
            r_sum[2] <= r_sum[2] + gif_pkg::SUM_W'(r_u2);
            r_sum[3] <= r_sum[3] + gif_pkg::SUM_W'(r_u3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cfg_w       <= gif_pkg::WIDTH_W'(256);
            r_cfg_h       <= gif_pkg::HEIGHT_W'(256);
            r_cfg_r       <= gif_pkg::RCFG_W'(1);
            r_cfg_eps     <= gif_pkg::EPS_W'(6554);
            r_load_idx    <= '0;
            r_emit        <= '0;
            r_ey          <= '0;
            r_ex          <= '0;
            r_frame_ready <= 1'b0;
            r_coef_mode   <= 1'b0;
            r_div_start   <= 1'b0;
            r_div_go      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (cfg_acc) begin
                        unique case (gif_pkg::t_reg_idx'(i_cfg.index))
                            gif_pkg::REG_WIDTH:  r_cfg_w   <= i_cfg.data[gif_pkg::WIDTH_W-1:0];
                            gif_pkg::REG_HEIGHT: r_cfg_h   <= i_cfg.data[gif_pkg::HEIGHT_W-1:0];
                            gif_pkg::REG_RADIUS: r_cfg_r   <= i_cfg.data[gif_pkg::RCFG_W-1:0];
                            gif_pkg::REG_EPS:    r_cfg_eps <= i_cfg.data[gif_pkg::EPS_W-1:0];
                            default: ;
                        endcase
                        r_load_idx    <= '0;
                        r_emit        <= '0;
                        r_ey          <= '0;
                        r_ex          <= '0;
                        r_frame_ready <= 1'b0;
                    end else if (in_acc && i_in.action == gif_pkg::ACT_LOAD) begin
                        // A load into a finished frame starts a new one.
                        r_frame_ready <= 1'b0;
                        r_load_idx    <= ld_next;
                        if (r_frame_ready) begin
                            r_emit <= '0;
                            r_ey   <= '0;
                            r_ex   <= '0;
                        end
                        if (ld_next >= n_pix) begin
                            r_coef_mode <= 1'b0;
                            r_py        <= '0;
                            r_px        <= '0;
                            r_pidx      <= '0;
                            r_state     <= S_SETUP;
                        end
                    end else if (in_acc) begin
                        if (!r_frame_ready || r_emit >= n_pix) begin
                            r_res_ok     <= 1'b0;
                            r_res_fp     <= 8'd0;
                            r_res_last   <= 1'b0;
                            r_res_status <= 1'b1;
                            r_state      <= S_OUT;
                        end else begin
                            r_coef_mode <= 1'b1;
                            r_py        <= r_ey;
                            r_px        <= r_ex;
                            r_state     <= S_SETUP;
                        end
                    end
                end
                S_SETUP: begin
                    r_y0    <= y_lo;
                    r_y1    <= y_hi;
                    r_x0    <= x_lo;
                    r_x1    <= x_hi;
                    r_state <= S_BASE;
                end
                S_BASE: begin
                    r_row_base <= gif_pkg::IDX_W'(r_y0 * w_eff);
                    r_count    <= gif_pkg::CNT_W'(span_y * span_x);
                    r_sy       <= r_y0;
                    r_sx       <= r_x0;
                    r_gi       <= pix_rd[15:8];
                    r_state    <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_sx == r_x1) begin
                        r_sx <= r_x0;
                        if (r_sy == r_y1) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_sy       <= r_sy + 1'b1;
                            r_row_base <= r_row_base + gif_pkg::IDX_W'(w_eff);
                        end
                    end else begin
                        r_sx <= r_sx + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (!r_v1 && !r_v2 && !r_v3) begin
                        r_k     <= 2'd0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (!r_div_go) begin
                        r_div_start <= 1'b1;
                        r_div_go    <= 1'b1;
                    end else if (div_done) begin
                        r_mean[r_k] <= gif_pkg::sat32(div_quo);
                        r_div_go    <= 1'b0;
                        if (r_k == k_last) begin
                            r_state <= r_coef_mode ? S_R_M : S_C_M1;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_C_M1: begin
                    r_prod  <= gif_pkg::qtrunc(mul_p);
                    r_state <= S_C_VAR;
                end
                S_C_VAR: begin
                    r_var   <= gif_pkg::sat32(var_full);
                    r_state <= S_C_M2;
                end
                S_C_M2: begin
                    r_prod  <= gif_pkg::qtrunc(mul_p);
                    r_state <= S_C_COV;
                end
                S_C_COV: begin
                    r_cov <= cov_v;
                    // A denominator that is not positive becomes the smallest step.
                    r_den <= (den_full <= 0) ? gif_pkg::DVS_W'(1)
                                             : den_full[gif_pkg::DVS_W-1:0];
                    r_state <= S_C_DIVA;
                end
                S_C_DIVA: begin
                    if (!r_div_go) begin
                        r_div_start <= 1'b1;
                        r_div_go    <= 1'b1;
                    end else if (div_done) begin
                        r_a      <= gif_pkg::sat32(div_quo);
                        r_div_go <= 1'b0;
                        r_state  <= S_C_M3;
                    end
                end
                S_C_M3: begin
                    r_prod  <= gif_pkg::qtrunc(mul_p);
                    r_state <= S_C_B;
                end
                S_C_B: begin
                    r_pidx <= r_pidx + 1'b1;
                    if (r_px == w_eff - 1'b1) begin
                        r_px <= '0;
                        if (r_py == h_eff - 1'b1) begin
                            r_frame_ready <= 1'b1;
                            r_emit        <= '0;
                            r_ey          <= '0;
                            r_ex          <= '0;
                            r_state       <= S_IDLE;
                        end else begin
                            r_py    <= r_py + 1'b1;
                            r_state <= S_SETUP;
                        end
                    end else begin
                        r_px    <= r_px + 1'b1;
                        r_state <= S_SETUP;
                    end
                end
                S_R_M: begin
                    r_prod  <= gif_pkg::qtrunc(mul_p);
                    r_state <= S_R_Q;
                end
                S_R_Q: begin
                    r_res_ok     <= 1'b1;
                    r_res_fp     <= fp_v;
                    r_res_last   <= (r_emit == n_pix - 1'b1);
                    r_res_status <= 1'b0;
                    r_state      <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_fp     <= r_res_fp;
                        r_out_last   <= r_res_last;
                        r_out_status <= r_res_status;
                        r_state      <= S_IDLE;
                        if (r_res_ok) begin
                            if (r_emit + 1'b1 >= n_pix) begin
                                r_emit <= '0;
                                r_ey   <= '0;
                                r_ex   <= '0;
                            end else begin
                                r_emit <= r_emit + 1'b1;
                                if (r_ex == w_eff - 1'b1) begin
                                    r_ex <= '0;
                                    r_ey <= r_ey + 1'b1;
                                end else begin
                                    r_ex <= r_ex + 1'b1;
                                end
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_double_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_acc && cfg_acc))
        else $error("input item and configuration write accepted together");

    a_scan_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (scan_addr < n_pix))
        else $error("window read outside the active frame");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> !div_busy)
        else $error("divider started while busy");

    a_ok_needs_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && r_res_ok) |-> r_frame_ready)
        else $error("filtered item without a finished frame");

endmodule

@@ tb/gif_tb_checker.sv @@
`timescale 1ns / 1ps
module gif_tb_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    gif_in_if    i_in,
    gif_out_if   i_out,
    gif_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    import gif_pkg::*;

    typedef struct packed {
        logic [7:0] filtered_pixel;
        logic       last;
        logic       status;
    } t_pixel_result;

    t_pixel_result pixel_q[$];

    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic [3:0]  radius_reg;
    logic [15:0] eps_reg;

    logic [7:0] guide_mem [PIX_DEPTH];
    logic [7:0] source_mem[PIX_DEPTH];
    int         coef_a_mem[PIX_DEPTH];
    int         coef_b_mem[PIX_DEPTH];
    int         load_pos;
    int         emit_pos;
    bit         frame_done;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fix_mul(longint x, longint y);
        longint p;
        p = x * y;
        if (p < 0) return -((-p) >> FRAC);
        return p >> FRAC;
    endfunction

    function automatic longint grey_to_fix(logic [7:0] g);
        return (longint'(g) << FRAC) / 255;
    endfunction

    function automatic int cur_w();
        if (width_reg < 1) return 1;
        return (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    endfunction

    function automatic int cur_h();
        if (height_reg < 1) return 1;
        return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    endfunction

    function automatic int cur_r();
        return (radius_reg > MAX_RADIUS) ? MAX_RADIUS : int'(radius_reg);
    endfunction

    // Kinds: 0 guide, 1 source, 2 guide squared, 3 guide times source, 4 a, 5 b.
    function automatic longint window_mean(int kind, int y, int x);
        int     w, h, r, y0, y1, x0, x1, idx;
        longint sum, iv, pv, v;
        w = cur_w();
        h = cur_h();
        r = cur_r();
        y0 = (y >= r) ? y - r : 0;
        x0 = (x >= r) ? x - r : 0;
        y1 = (y + r < h) ? y + r : h - 1;
        x1 = (x + r < w) ? x + r : w - 1;
        sum = 0;
        for (int yy = y0; yy <= y1; yy++) begin
            for (int xx = x0; xx <= x1; xx++) begin
                idx = yy * w + xx;
                iv = grey_to_fix(guide_mem[idx]);
                pv = grey_to_fix(source_mem[idx]);
                case (kind)
                    0: v = iv;
                    1: v = pv;
                    2: v = fix_mul(iv, iv);
                    3: v = fix_mul(iv, pv);
                    4: v = coef_a_mem[idx];
                    default: v = coef_b_mem[idx];
                endcase
                sum += v;
            end
        end
        return clamp32(sum / (longint'(y1 - y0 + 1) * longint'(x1 - x0 + 1)));
    endfunction

    task automatic solve_coefficients();
        int     w, h, idx;
        longint eps, mi, mp, mii, mip, var_i, cov_ip, den, a, b;
        w = cur_w();
        h = cur_h();
        eps = longint'(eps_reg) << 8;
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                idx = y * w + x;
                mi = window_mean(0, y, x);
                mp = window_mean(1, y, x);
                mii = window_mean(2, y, x);
                mip = window_mean(3, y, x);
                var_i = clamp32(mii - fix_mul(mi, mi));
                cov_ip = clamp32(mip - fix_mul(mi, mp));
                den = var_i + eps;
                if (den <= 0) den = 1;
                a = clamp32((cov_ip * (64'sd1 << FRAC)) / den);
                b = clamp32(mp - fix_mul(a, mi));
                coef_a_mem[idx] = int'(a);
                coef_b_mem[idx] = int'(b);
            end
        end
    endtask

    task automatic predict_item(logic act, logic [7:0] g, logic [7:0] s);
        int            n, y, x;
        longint        ma, mb, q, sc, v;
        t_pixel_result res;
        n = cur_w() * cur_h();
        if (act == ACT_LOAD) begin
            if (frame_done) begin
                load_pos = 0;
                emit_pos = 0;
                frame_done = 0;
            end
            if (load_pos < n) begin
                guide_mem[load_pos] = g;
                source_mem[load_pos] = s;
                load_pos++;
            end
            if (load_pos >= n) begin
                solve_coefficients();
                frame_done = 1;
                emit_pos = 0;
            end
        end else if (!frame_done || emit_pos >= n) begin
            res = '{filtered_pixel: 8'd0, last: 1'b0, status: 1'b1};
            pixel_q.push_back(res);
        end else begin
            y = emit_pos / cur_w();
            x = emit_pos % cur_w();
            ma = window_mean(4, y, x);
            mb = window_mean(5, y, x);
            q = clamp32(fix_mul(ma, grey_to_fix(guide_mem[emit_pos])) + mb);
            sc = q * 255;
            v = (sc < 0) ? 0 : (sc >> FRAC);
            if (v > 255) v = 255;
            res.filtered_pixel = v[7:0];
            res.last = (emit_pos == n - 1);
            res.status = 1'b0;
            pixel_q.push_back(res);
            emit_pos = (emit_pos + 1 >= n) ? 0 : emit_pos + 1;
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel_result got, want;
        if (!i_rst_n) begin
            width_reg <= 9'd256;
            height_reg <= 9'd256;
            radius_reg <= 4'd1;
            eps_reg <= 16'd6554;
            load_pos = 0;
            emit_pos = 0;
            frame_done = 0;
            pixel_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_reg_idx'(i_cfg.index))
                    REG_WIDTH:  width_reg <= i_cfg.data[8:0];
                    REG_HEIGHT: height_reg <= i_cfg.data[8:0];
                    REG_RADIUS: radius_reg <= i_cfg.data[3:0];
                    REG_EPS:    eps_reg <= i_cfg.data[15:0];
                    default: ;
                endcase
                load_pos = 0;
                emit_pos = 0;
                frame_done = 0;
            end
            if (i_in.valid && i_in.ready)
                predict_item(i_in.action, i_in.guide_pixel, i_in.source_pixel);
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.filtered_pixel, i_out.last, i_out.status};
                if (pixel_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result: pixel %0d last %0d status %0d",
                                 got.filtered_pixel, got.last, got.status);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = pixel_q.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display("mismatch: pixel %0d/%0d last %0d/%0d status %0d/%0d (exp/got)",
                                     want.filtered_pixel, got.filtered_pixel,
                                     want.last, got.last, want.status, got.status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= pixel_q.size();
    end
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import gif_pkg::*;

    localparam int IDLE_LIMIT = 1000000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   items_sent;
    int   idle_cycles;
    int   hold_asked;
    bit   no_idle;
    bit   maybe_busy;
    logic [8:0] w_set;
    logic [8:0] h_set;
    logic [3:0] r_set;

    gif_in_if  in_ch();
    gif_out_if out_ch();
    gif_cfg_if cfg_ch();

    guided_image_filter_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    gif_tb_checker checker_0 (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int frame_pixels();
        int w, h;
        w = (w_set < 1) ? 1 : ((w_set > MAX_WIDTH) ? MAX_WIDTH : int'(w_set));
        h = (h_set < 1) ? 1 : ((h_set > MAX_HEIGHT) ? MAX_HEIGHT : int'(h_set));
        return w * h;
    endfunction

    function automatic int window_pixels();
        int r;
        r = (r_set > MAX_RADIUS) ? MAX_RADIUS : int'(r_set);
        return (2 * r + 1) * (2 * r + 1);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[guided_image_filter_unit] ERROR");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off whenever one is asked for.
    initial begin
        int gap, holds_done;
        holds_done = 0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_asked != holds_done) begin
                holds_done = hold_asked;
                gap = 600;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, 18);
            end
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            begin
                bit acc;
                do begin
                    @(negedge i_clk);
                    acc = out_ch.valid && out_ch.ready;
                    @(posedge i_clk);
                end while (!acc);
            end
        end
    end

    task automatic send_item(logic act, logic [7:0] g, logic [7:0] s);
        int gap;
        bit acc;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.guide_pixel <= g;
        in_ch.source_pixel <= s;
        do begin
            @(negedge i_clk);
            acc = in_ch.valid && in_ch.ready;
            @(posedge i_clk);
        end while (!acc);
        items_sent++;
        if (act == ACT_LOAD) maybe_busy = 1;
    endtask

    // Lets the block drain: all results back, then room for a coefficient pass.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        @(posedge i_clk);
        if (maybe_busy)
            repeat (frame_pixels() * (window_pixels() + 320) + 400) @(posedge i_clk);
        maybe_busy = 0;
    endtask

    task automatic write_reg(t_reg_idx idx, logic [15:0] value);
        bit acc;
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do begin
            @(negedge i_clk);
            acc = cfg_ch.valid && cfg_ch.ready;
            @(posedge i_clk);
        end while (!acc);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_WIDTH:  w_set = value[8:0];
            REG_HEIGHT: h_set = value[8:0];
            REG_RADIUS: r_set = value[3:0];
            default: ;
        endcase
    endtask

    task automatic load_frame(int kind);
        int n;
        logic [7:0] g, s;
        n = frame_pixels();
        g = $urandom;
        s = $urandom;
        for (int i = 0; i < n; i++) begin
            // Kind 0 random, 1 flat, 2 extremes only.
            if (kind == 0) begin
                g = $urandom;
                s = $urandom;
            end else if (kind == 2) begin
                g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                s = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            send_item(ACT_LOAD, g, s);
        end
    endtask

    task automatic request_pixels(int count);
        for (int i = 0; i < count; i++) send_item(ACT_REQUEST, $urandom, $urandom);
    endtask

    initial begin
        int n, pick, phase;
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.action <= ACT_LOAD;
        in_ch.guide_pixel <= 8'd0;
        in_ch.source_pixel <= 8'd0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_WIDTH;
        cfg_ch.data <= 16'd0;
        items_sent = 0;
        hold_asked = 0;
        no_idle = 0;
        maybe_busy = 0;
        w_set = 9'd256;
        h_set = 9'd256;
        r_set = 4'd1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: early request, tiny frames, extremes, zero regularizer, wrap.
        send_item(ACT_REQUEST, 8'd0, 8'd0);
        write_reg(REG_WIDTH, 16'd2);
        write_reg(REG_HEIGHT, 16'd2);
        write_reg(REG_RADIUS, 16'd0);
        write_reg(REG_EPS, 16'd1);
        send_item(ACT_LOAD, 8'd0, 8'd255);
        send_item(ACT_REQUEST, 8'd0, 8'd0);
        send_item(ACT_LOAD, 8'd255, 8'd0);
        send_item(ACT_LOAD, 8'd255, 8'd255);
        send_item(ACT_LOAD, 8'd0, 8'd0);
        request_pixels(5);
        send_item(ACT_LOAD, 8'd128, 8'd77);
        send_item(ACT_REQUEST, 8'd255, 8'd255);
        wait_idle();
        write_reg(REG_EPS, 16'd0);
        write_reg(REG_RADIUS, 16'd15);
        load_frame(1);
        request_pixels(4);
        write_reg(REG_EPS, 16'd65535);
        write_reg(REG_WIDTH, 16'd0);
        load_frame(2);
        request_pixels(3);

        phase = 0;
        while (items_sent < 1750) begin
            no_idle = ($urandom_range(0, 5) == 0);
            if (phase == 3) begin
                write_reg(REG_WIDTH, 16'd300);
                write_reg(REG_HEIGHT, 16'd1);
                write_reg(REG_RADIUS, 16'd8);
            end else if (phase == 7) begin
                write_reg(REG_WIDTH, 16'd1);
                write_reg(REG_HEIGHT, 16'd256);
            end else begin
                if ($urandom_range(0, 1))
                    write_reg(REG_WIDTH, {$urandom_range(0, 127), 9'(0)} |
                              16'($urandom_range(1, 8)));
                if ($urandom_range(0, 1))
                    write_reg(REG_HEIGHT, {$urandom_range(0, 127), 9'(0)} |
                              16'($urandom_range(1, 8)));
                if ($urandom_range(0, 1))
                    write_reg(REG_RADIUS, 16'($urandom));
                if ($urandom_range(0, 1)) begin
                    pick = $urandom_range(0, 3);
                    write_reg(REG_EPS, (pick == 0) ? 16'd0 :
                              (pick == 1) ? 16'hFFFF : 16'($urandom));
                end
                // Oversized settings would make the pass too slow.
                if (frame_pixels() > 64) write_reg(REG_HEIGHT, 16'd3);
            end
            n = frame_pixels();
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
                request_pixels($urandom_range(0, 2));
                if (pick == 1 && n > 1) begin
                    load_frame(0);
                    request_pixels($urandom_range(1, n - 1));
                end
                load_frame(($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0);
                if (phase == 1) begin
                    hold_asked++;
                    no_idle = 1;
                end
                request_pixels(n + $urandom_range(0, 3));
            end else begin
                for (int i = 0; i < 2 * n + 2; i++)
                    send_item($urandom_range(0, 1) ? ACT_REQUEST : ACT_LOAD,
                              $urandom, $urandom);
            end
            phase++;
        end

        wait_idle();
        repeat (400) @(posedge i_clk);
        if (fail_count == 0)
            $display("[guided_image_filter_unit] OK");
        else
            $display("[guided_image_filter_unit] ERROR");
        $finish;
    end
endmodule

@@ guided_image_filter_unit.f @@
rtl/core/gif_pkg.sv
rtl/core/gif_in_if.sv
rtl/core/gif_out_if.sv
rtl/core/gif_cfg_if.sv
rtl/core/gif_ram.sv
rtl/core/gif_div.sv
rtl/core/guided_image_filter_unit.sv
tb/gif_tb_checker.sv
tb/tb.sv
